>>> rtl/core/lift_preset_stop_sequencer_defines.svh
// ---------------------------------------------------------------------------
// Lift preset stop sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef LIFT_PRESET_STOP_SEQUENCER_DEFINES_SVH
`define LIFT_PRESET_STOP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lift sequencer assertion failed");

// Next-cycle implication, checked out of reset.
`define LPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lift sequencer assertion failed");

`endif

>>> rtl/core/lpss_pkg.sv
// ---------------------------------------------------------------------------
// Lift preset stop sequencer package
// Stage codes, configuration indexes and shared structures.
// ---------------------------------------------------------------------------
package lpss_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned DELTA_W  = HEIGHT_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLIANCE = 2'd3;

  // Reset heights, unsigned Q0.16.
  localparam logic [HEIGHT_W-1:0] RST_LOWEST   = 16'd0;
  localparam logic [HEIGHT_W-1:0] RST_GOAL     = 16'd16384;
  localparam logic [HEIGHT_W-1:0] RST_WALL     = 16'd32768;
  localparam logic [HEIGHT_W-1:0] RST_ALLIANCE = 16'd49152;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_LOWEST    = 4'd1,
    ST_RISING    = 4'd2,
    ST_GOAL      = 4'd3,
    ST_GOAL_DOWN = 4'd4,
    ST_GOAL_UP   = 4'd5,
    ST_WALL      = 4'd6,
    ST_WALL_DOWN = 4'd7,
    ST_WALL_UP   = 4'd8,
    ST_ALLI      = 4'd9,
    ST_ALLI_DOWN = 4'd10
  } stage_t;

  // The four preset stop heights.
  typedef struct packed {
    logic [HEIGHT_W-1:0] lowest;
    logic [HEIGHT_W-1:0] goal;
    logic [HEIGHT_W-1:0] wall;
    logic [HEIGHT_W-1:0] alliance;
  } heights_t;

  // Outcome of one control tick.
  typedef struct packed {
    logic                      move_valid;
    logic signed [DELTA_W-1:0] move_delta;
    stage_t                    stage;
  } step_res_t;

endpackage

>>> rtl/core/lpss_cfg_regs.sv
// ---------------------------------------------------------------------------
// Lift preset stop sequencer configuration registers
// Holds the four stop heights, written through the plain write port.
// ---------------------------------------------------------------------------
module lpss_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lpss_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [lpss_pkg::HEIGHT_W-1:0]      cfg_wdata,
  output lpss_pkg::heights_t                 heights
);
  import lpss_pkg::*;

  heights_t heights_r;

  // Register file with per-index write decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heights_r.lowest   <= RST_LOWEST;
      heights_r.goal     <= RST_GOAL;
      heights_r.wall     <= RST_WALL;
      heights_r.alliance <= RST_ALLIANCE;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_LOWEST:   heights_r.lowest   <= cfg_wdata;
        CFG_GOAL:     heights_r.goal     <= cfg_wdata;
        CFG_WALL:     heights_r.wall     <= cfg_wdata;
        CFG_ALLIANCE: heights_r.alliance <= cfg_wdata;
        default:      heights_r          <= heights_r;
      endcase
    end
  end

  assign heights = heights_r;

endmodule

>>> rtl/core/lpss_step.sv
// ---------------------------------------------------------------------------
// Lift preset stop sequencer step logic
// Next-stage decode and the single relative-move subtraction for one tick.
// ---------------------------------------------------------------------------
module lpss_step (
  input  lpss_pkg::stage_t    stage,
  input  logic                up_pressed,
  input  logic                down_pressed,
  input  logic                motor_moving,
  input  lpss_pkg::heights_t  heights,
  output lpss_pkg::step_res_t res
);
  import lpss_pkg::*;

  logic                only_up;
  logic                only_down;
  logic                take;
  logic [HEIGHT_W-1:0] to_h;
  logic [HEIGHT_W-1:0] from_h;
  stage_t              stage_nxt;
  logic                valid;

  assign only_up   = up_pressed && !down_pressed;
  assign only_down = down_pressed && !up_pressed;

  // Decode the stage, pick the height pair for a new move.
  always_comb begin
    stage_nxt = stage;
    valid     = 1'b0;
    take      = 1'b0;
    to_h      = heights.lowest;
    from_h    = heights.lowest;
    unique case (stage)
      ST_LOWEST: begin
        valid = 1'b1;
        if (up_pressed) begin
          stage_nxt = ST_RISING;
          take      = 1'b1;
          to_h      = heights.goal;
          from_h    = heights.lowest;
        end
      end
      ST_GOAL: begin
        valid = 1'b1;
        if (only_up) begin
          stage_nxt = ST_GOAL_UP;
          take      = 1'b1;
          to_h      = heights.wall;
          from_h    = heights.goal;
        end else if (only_down) begin
          stage_nxt = ST_GOAL_DOWN;
          take      = 1'b1;
          to_h      = heights.lowest;
          from_h    = heights.goal;
        end
      end
      ST_WALL: begin
        valid = 1'b1;
        if (only_down) begin
          stage_nxt = ST_WALL_DOWN;
          take      = 1'b1;
          to_h      = heights.goal;
          from_h    = heights.wall;
        end else if (only_up) begin
          stage_nxt = ST_WALL_UP;
          take      = 1'b1;
          to_h      = heights.alliance;
          from_h    = heights.wall;
        end
      end
      ST_ALLI: begin
        valid = 1'b1;
        if (down_pressed) begin
          stage_nxt = ST_ALLI_DOWN;
          take      = 1'b1;
          to_h      = heights.wall;
          from_h    = heights.alliance;
        end
      end
      ST_RISING, ST_GOAL_UP, ST_WALL_UP: begin
        if (!motor_moving) begin
          valid = 1'b1;
          if (!up_pressed) begin
            priority case (stage)
              ST_RISING:  stage_nxt = ST_GOAL;
              ST_GOAL_UP: stage_nxt = ST_WALL;
              default:    stage_nxt = ST_ALLI;
            endcase
          end
        end
      end
      ST_GOAL_DOWN, ST_WALL_DOWN, ST_ALLI_DOWN: begin
        if (!motor_moving) begin
          valid = 1'b1;
          if (!down_pressed) begin
            priority case (stage)
              ST_GOAL_DOWN: stage_nxt = ST_LOWEST;
              ST_WALL_DOWN: stage_nxt = ST_GOAL;
              default:      stage_nxt = ST_WALL;
            endcase
          end
        end
      end
      default: begin
        // Start and unused codes head to the lowest stop without a move.
        stage_nxt = ST_LOWEST;
      end
    endcase
  end

  // One 17-bit subtract; zero when no move is started.
  assign res.move_delta = take ? ($signed({1'b0, to_h}) - $signed({1'b0, from_h}))
                               : '0;
  assign res.move_valid = valid;
  assign res.stage      = stage_nxt;

endmodule

>>> rtl/core/lift_preset_stop_sequencer.sv
// ---------------------------------------------------------------------------
// Lift preset stop sequencer
// Moves a lift between four preset stops, one control tick per word.
// ---------------------------------------------------------------------------
// The block accepts one tick word per clock cycle while in_stall is low and
// returns one result word per tick. A word sits in the input register,
// passes through the stage decode and one 17-bit height subtraction, and lands
// in the result register; the stage register updates as the word moves on, so
// the next word sees the new stage. The input side stalls only while both
// registers hold words and the result side stalls. Heights are to be written
// through the cfg port while the block is idle; the block does not enforce it.
`include "lift_preset_stop_sequencer_defines.svh"

module lift_preset_stop_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [lpss_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [lpss_pkg::HEIGHT_W-1:0]         cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_up_pressed,
  input  logic                                  in_down_pressed,
  input  logic                                  in_motor_moving,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_move_valid,
  output logic signed [lpss_pkg::DELTA_W-1:0]   out_move_delta,
  output logic [3:0]                            out_stage
);
  import lpss_pkg::*;

  heights_t  heights;
  step_res_t res;

  logic   in_vld_r;
  logic   in_up_r;
  logic   in_down_r;
  logic   in_moving_r;
  logic   out_vld_r;
  stage_t stage_r;
  logic   out_move_valid_r;
  logic signed [DELTA_W-1:0] out_move_delta_r;
  stage_t out_stage_r;

  logic advance;
  logic in_take;
  logic out_travel;

  lpss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .heights   (heights)
  );

  lpss_step u_step (
    .stage        (stage_r),
    .up_pressed   (in_up_r),
    .down_pressed (in_down_r),
    .motor_moving (in_moving_r),
    .heights      (heights),
    .res          (res)
  );

  // The result register frees when empty or taken this cycle.
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_up_r     <= in_up_pressed;
      in_down_r   <= in_down_pressed;
      in_moving_r <= in_motor_moving;
    end
  end

  // Stage register and result register, loaded as a word moves across.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      stage_r   <= ST_START;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        stage_r <= res.stage;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_move_valid_r <= res.move_valid;
      out_move_delta_r <= res.move_delta;
      out_stage_r      <= res.stage;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_move_valid = out_move_valid_r;
  assign out_move_delta = out_move_delta_r;
  assign out_stage      = out_stage_r;

  // Travel stages are the only ones entered together with a move.
  assign out_travel = (out_stage_r == ST_RISING) || (out_stage_r == ST_GOAL_UP) ||
                      (out_stage_r == ST_WALL_UP) || (out_stage_r == ST_GOAL_DOWN) ||
                      (out_stage_r == ST_WALL_DOWN) || (out_stage_r == ST_ALLI_DOWN);

  // A word without a move always carries a zero delta.
  `LPSS_ASSERT_IMPLIES(a_idle_zero_delta, clk, rst_n, out_valid && !out_move_valid, out_move_delta == '0)

  // A nonzero delta only comes with entry into a travel stage.
  `LPSS_ASSERT_IMPLIES(a_delta_travel, clk, rst_n, out_valid && (out_move_delta != '0), out_travel)

  // The input side stalls only when a result is waiting and held back.
  `LPSS_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule
